// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;
    localparam int LIVE_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (CAP_W > LIVE_W) ? CAP_W : LIVE_W;

    // Operation carried in tuser.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Commands broadcast to every cell of the chain.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_MATCH  = 2'd1;
    localparam logic [1:0] MODE_BUMP   = 2'd2;
    localparam logic [1:0] MODE_INSERT = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } cell_data_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             evict;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } cell_cmd_t;

endpackage

// ===== rtl/core/lfu_cell.sv =====
module lfu_cell import lfu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       first,
    input  cell_cmd_t  cmd,
    input  cell_data_t left_in,
    input  logic       left_le,
    input  logic       left_past,
    input  cell_data_t right_in,
    input  logic       right_le,
    output cell_data_t data_q,
    output logic       le,
    output logic       past,
    output logic       match
);

    cell_data_t data_reg;
    cell_data_t data_next;
    logic       match_reg;
    logic       match_next;
    logic       mark;
    cell_data_t new_entry;

    always_comb begin
        // The cell being removed: the matched entry, or the head on an eviction.
        mark = cmd.evict ? first : match_reg;
        // On a bump only cells to the right of the removed one may move left.
        le   = data_reg.valid && (data_reg.count <= cmd.count)
               && ((cmd.mode == MODE_INSERT) || left_past);
        past = left_past | mark;

        new_entry.valid = 1'b1;
        new_entry.key   = cmd.key;
        new_entry.value = cmd.value;
        new_entry.count = cmd.count;

        data_next  = data_reg;
        match_next = match_reg;
        unique case (cmd.mode)
            MODE_MATCH: begin
                match_next = data_reg.valid && (data_reg.key == cmd.key);
            end
            MODE_BUMP: begin
                if (past) begin
                    if (right_le) begin
                        data_next = right_in;
                    end else if (mark || le) begin
                        data_next = new_entry;
                    end
                end
            end
            MODE_INSERT: begin
                if (!le) begin
                    if (first || left_le) begin
                        data_next = new_entry;
                    end else begin
                        data_next = left_in;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
            match_reg      <= 1'b0;
        end else begin
            data_reg.valid <= data_next.valid;
            match_reg      <= match_next;
        end
        data_reg.key   <= data_next.key;
        data_reg.value <= data_next.value;
        data_reg.count <= data_next.count;
    end

    assign data_q = data_reg;
    assign match  = match_reg;

endmodule

// ===== rtl/core/lfu_cache_lru_tiebreak_top.sv =====
// Fully associative key-value cache of 16 entries with least-frequently-used
// replacement, ties going to the least recently used entry. The entries sit
// in a chain of cells kept in eviction order: the head is always the victim,
// and an access that raises a count moves its entry right past all entries
// of lower or equal count, so no search for a minimum is needed. Every
// transaction goes through three steps after acceptance: the key is compared
// in all cells at once, the hit is gathered and the command worked out, and
// the cells shift as the result is handed to the output register, or held
// until that register is free.
// A new transaction is accepted once the previous one has been handed to the
// output register, which may still hold it while the next one is processed.
// The capacity register takes effect from the next put; lowering it evicts
// nothing at once, but each later inserting put then evicts one entry first.
module lfu_cache_lru_tiebreak_top import lfu_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]       s_tuser,   // op (0 get, 1 put)
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // read_value [31:0]
    output logic [0:0]       m_tuser,   // hit
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [LIVE_W-1:0] live_reg, live_next;
    cell_cmd_t         cmd_reg, cmd_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              res_hit_reg, res_hit_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_data_reg;
    logic              out_hit_reg;

    cell_data_t        cell_q  [ENTRIES];
    cell_data_t        left_d  [ENTRIES];
    cell_data_t        right_d [ENTRIES];
    logic [ENTRIES-1:0] le_vec, past_vec, match_vec, valid_vec;
    logic [ENTRIES-1:0] left_le_vec, left_past_vec, right_le_vec;
    logic [ENTRIES-1:0] valid_inc;

    logic              in_fire, out_free, load_out;
    logic              hit_any;
    logic [VAL_W-1:0]  rd_val;
    logic [CNT_W-1:0]  fcnt, cnt_inc;
    logic [CMP_W-1:0]  cap_w, ent_w, live_w, cap_eff;
    logic              full, cap_zero;

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign left_d[i]        = '0;
                assign left_le_vec[i]   = 1'b0;
                assign left_past_vec[i] = 1'b0;
            end else begin : g_mid
                assign left_d[i]        = cell_q[i-1];
                assign left_le_vec[i]   = le_vec[i-1];
                assign left_past_vec[i] = past_vec[i-1];
            end
            if (i == ENTRIES - 1) begin : g_tail
                assign right_d[i]      = '0;
                assign right_le_vec[i] = 1'b0;
            end else begin : g_body
                assign right_d[i]      = cell_q[i+1];
                assign right_le_vec[i] = le_vec[i+1];
            end

            lfu_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .first     (i == 0),
                .cmd       (cmd_reg),
                .left_in   (left_d[i]),
                .left_le   (left_le_vec[i]),
                .left_past (left_past_vec[i]),
                .right_in  (right_d[i]),
                .right_le  (right_le_vec[i]),
                .data_q    (cell_q[i]),
                .le        (le_vec[i]),
                .past      (past_vec[i]),
                .match     (match_vec[i])
            );

            assign valid_vec[i] = cell_q[i].valid;
        end
    endgenerate

    assign valid_inc = valid_vec + 1'b1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Gather the matching entry; keys are unique so at most one cell matches.
    always_comb begin
        hit_any = |match_vec;
        rd_val  = '0;
        fcnt    = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            rd_val = rd_val | (cell_q[k].value & {VAL_W{match_vec[k]}});
            fcnt   = fcnt | (cell_q[k].count & {CNT_W{match_vec[k]}});
        end
        cnt_inc  = (fcnt == {CNT_W{1'b1}}) ? fcnt : CNT_W'(fcnt + 1'b1);
        cap_w    = CMP_W'(capacity_reg);
        ent_w    = CMP_W'(ENTRIES);
        live_w   = CMP_W'(live_reg);
        cap_eff  = (cap_w > ent_w) ? ent_w : cap_w;
        full     = (live_w >= cap_eff);
        cap_zero = (cap_eff == '0);
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        live_next    = live_reg;
        res_hit_next = res_hit_reg;
        res_val_next = res_val_reg;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd_next.mode  = MODE_MATCH;
                    cmd_next.evict = 1'b0;
                    cmd_next.key   = s_tdata[31:0];
                    state_next     = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd_next.mode = MODE_NONE;
                state_next    = ST_PREP;
            end
            ST_PREP: begin
                res_hit_next   = hit_any;
                res_val_next   = '0;
                cmd_next.mode  = MODE_NONE;
                cmd_next.evict = 1'b0;
                cmd_next.key   = key_reg;
                cmd_next.value = val_reg;
                cmd_next.count = cnt_inc;
                if (op_reg == OP_GET) begin
                    if (hit_any) begin
                        res_val_next   = rd_val;
                        cmd_next.mode  = MODE_BUMP;
                        cmd_next.value = rd_val;
                    end
                end else if (!cap_zero) begin
                    if (hit_any) begin
                        cmd_next.mode = MODE_BUMP;
                    end else if (full) begin
                        // Drop the head of the chain and insert with a count of one.
                        cmd_next.mode  = MODE_BUMP;
                        cmd_next.evict = 1'b1;
                        cmd_next.count = CNT_W'(1);
                    end else begin
                        cmd_next.mode  = MODE_INSERT;
                        cmd_next.count = CNT_W'(1);
                    end
                end
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // The live count steps together with the cells taking the new entry.
                if (cmd_reg.mode == MODE_INSERT) begin
                    live_next = LIVE_W'(live_reg + 1'b1);
                end
                cmd_next.mode  = MODE_NONE;
                cmd_next.evict = 1'b0;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_W'(16);
            live_reg       <= '0;
            cmd_reg.mode   <= MODE_NONE;
            cmd_reg.evict  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            cmd_reg.mode  <= cmd_next.mode;
            cmd_reg.evict <= cmd_next.evict;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        cmd_reg.key   <= cmd_next.key;
        cmd_reg.value <= cmd_next.value;
        cmd_reg.count <= cmd_next.count;
        res_hit_reg   <= res_hit_next;
        res_val_reg   <= res_val_next;
        if (in_fire) begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata[31:0];
            val_reg <= s_tdata[63:32];
        end
        if (load_out) begin
            out_hit_reg  <= res_hit_reg;
            out_data_reg <= res_val_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_hit_reg;

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LIVE_W'(ENTRIES))
        else $error("live entry count exceeds the number of cells");

    a_live_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == live_reg)
        else $error("live entry count disagrees with the valid cells");

    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & valid_inc) == '0)
        else $error("valid cells are not packed at the head of the chain");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PREP |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_accept_starts_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_LOOK) && (cmd_reg.mode == MODE_MATCH))
        else $error("accepted transaction did not start a key lookup");

endmodule
